@@ rtl/fwh_pkg.sv @@
`timescale 1ns / 1ps

package fwh_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int IDX_W     = 8;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int BCNT_W    = 9;
    // Common width for bin and index compares (holds a 16-bit quotient and the bin limit)
    localparam int CMP_W     = 17;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ACC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

    // Divider request and response
    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] dividend;
        logic [SAMPLE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/fwh_ram.sv @@
`timescale 1ns / 1ps

module fwh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fwh_div.sv @@
`timescale 1ns / 1ps

module fwh_div
    import fwh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(SAMPLE_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] r_rem;
    logic [SAMPLE_W-1:0] r_quo;
    logic [SAMPLE_W-1:0] r_den;

    logic [SAMPLE_W:0]   rem_sh;
    logic [SAMPLE_W:0]   rem_sub;
    logic                ge;
    logic [SAMPLE_W-1:0] rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {r_rem, r_quo[SAMPLE_W-1]};
        ge       = rem_sh >= {1'b0, r_den};
        rem_sub  = rem_sh - {1'b0, r_den};
        rem_next = ge ? rem_sub[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SAMPLE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[SAMPLE_W-2:0], ge};
        end
    end

    assign o_rsp = {r_done, r_quo};

endmodule

@@ rtl/fixed_width_histogram_unit.sv @@
`timescale 1ns / 1ps
// Accumulate: busy from the request through the bit-serial divider,
//   then a bin read and a saturating write back; the unit takes no new request while busy.
// Read: registered RAM read, then the result strobe (the strobe alone for an index past the store).
// Clear and unused modes: done in the request cycle. The receiver cannot stall results.
// Reset (synchronous, active low) starts a clearing pass over all NUM_BINS bins with busy high.

module fixed_width_histogram_unit
    import fwh_pkg::*;
#(
    parameter int NUM_BINS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic [IDX_W-1:0]     i_bin_index,
    output logic                 o_valid,
    output logic [DATA_W-1:0]    o_bin_total,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int             AW        = $clog2(NUM_BINS);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(NUM_BINS - 1);
    localparam logic [CMP_W-1:0] NB_CMP  = CMP_W'(NUM_BINS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_INC   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    // Configuration
    logic [SAMPLE_W-1:0] r_min_value;
    logic [CFG_W-1:0]    r_bin_width;
    logic [BCNT_W-1:0]   r_bin_count;

    // Sequencer state
    logic [2:0]          r_state,    n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic [SAMPLE_W-1:0] r_sample,   n_sample;
    logic                r_neg,      n_neg;
    logic [AW-1:0]       r_addr,     n_addr;
    logic                r_valid,    n_valid;
    logic [DATA_W-1:0]   r_total,    n_total;

    // RAM ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    // Datapath
    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic [CMP_W-1:0]    idx_cmp;
    logic                idx_ok;
    logic [AW-1:0]       idx_addr;
    logic [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]   mag;
    logic [CMP_W-1:0]    bc_cmp;
    logic [CMP_W-1:0]    n_use;
    logic [CMP_W-1:0]    last_bin;
    logic [CMP_W-1:0]    q_cmp;
    logic [CMP_W-1:0]    sel_cmp;
    logic [AW-1:0]       bin_sel;
    logic [DATA_W-1:0]   inc_val;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value <= '0;
            r_bin_width <= CFG_W'(1);
            r_bin_count <= BCNT_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_VALUE: r_min_value <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_BIN_WIDTH: r_bin_width <= i_cfg_wdata;
                CFG_BIN_COUNT: r_bin_count <= i_cfg_wdata[BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the addressed bin of read and clear requests
    always_comb begin
        idx_cmp  = CMP_W'(i_bin_index);
        idx_ok   = idx_cmp < NB_CMP;
        idx_addr = idx_cmp[AW-1:0];
    end

    // Form the magnitude of sample minus origin for the divider
    always_comb begin
        diff = {r_sample[SAMPLE_W-1], r_sample} - {r_min_value[SAMPLE_W-1], r_min_value};
        mag  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    end

    // Load the divider with the magnitude and a nonzero bin width
    always_comb begin
        div_req.start    = (r_state == S_PREP);
        div_req.dividend = mag[SAMPLE_W-1:0];
        div_req.divisor  = (r_bin_width == '0) ? SAMPLE_W'(1) : r_bin_width;
    end

    fwh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Map the quotient to a bin, folding overflow and negative differences of a bin width or more into the last bin
    always_comb begin
        bc_cmp   = CMP_W'(r_bin_count);
        if (bc_cmp == '0) begin
            n_use = CMP_W'(1);
        end else if (bc_cmp > NB_CMP) begin
            n_use = NB_CMP;
        end else begin
            n_use = bc_cmp;
        end
        last_bin = n_use - 1'b1;
        q_cmp    = CMP_W'(div_rsp.quotient);
        if (r_neg) begin
            sel_cmp = (q_cmp != '0) ? last_bin : '0;
        end else begin
            sel_cmp = (q_cmp >= n_use) ? last_bin : q_cmp;
        end
        bin_sel  = sel_cmp[AW-1:0];
    end

    // Saturating increment of the fetched counter
    assign inc_val = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_sample   = r_sample;
        n_neg      = r_neg;
        n_addr     = r_addr;
        n_valid    = 1'b0;
        n_total    = r_total;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = idx_addr;
        case (r_state)
            S_CLEAR: begin
                // Sweep the store to zero
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_mode)
                        MODE_ACC: begin
                            n_sample = i_sample;
                            n_state  = S_PREP;
                        end
                        MODE_READ: begin
                            if (idx_ok) begin
                                ram_re  = 1'b1;
                                n_state = S_READ;
                            end else begin
                                n_valid = 1'b1;
                                n_total = '0;
                            end
                        end
                        MODE_CLEAR: begin
                            if (idx_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_addr;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PREP: begin
                // Divider loads this cycle; keep the sign for bin mapping
                n_neg   = diff[SAMPLE_W];
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    ram_re    = 1'b1;
                    ram_raddr = bin_sel;
                    n_addr    = bin_sel;
                    n_state   = S_INC;
                end
            end
            S_INC: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = inc_val;
                n_state   = S_IDLE;
            end
            S_READ: begin
                n_valid = 1'b1;
                n_total = ram_rdata;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_neg    <= n_neg;
        r_addr   <= n_addr;
        r_total  <= n_total;
    end

    fwh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_bin_total = r_total;

endmodule

@@ rtl/fwh_checker.sv @@
`timescale 1ns / 1ps

module fwh_checker
    import fwh_pkg::*;
#(
    parameter int NUM_BINS = 256
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic [MODE_W-1:0]    i_mode,
    input logic [IDX_W-1:0]     i_bin_index,
    input logic                 o_valid,
    input logic [DATA_W-1:0]    o_bin_total
);

    logic acc_read;
    logic acc_accum;
    logic idx_in_store;

    assign acc_read     = i_start && !o_busy && (i_mode == MODE_READ);
    assign acc_accum    = i_start && !o_busy && (i_mode == MODE_ACC);
    assign idx_in_store = CMP_W'(i_bin_index) < CMP_W'(NUM_BINS);

    // Reset starts the clearing pass with no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy && !o_valid)
        else $error("reset did not start clearing pass");

    // Read inside the store returns its result after the RAM read and the read state
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_read && idx_in_store |-> ##2 o_valid)
        else $error("read result missing");

    // Read past the store returns zero on the next cycle
    a_read_oob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_read && !idx_in_store |=> o_valid && (o_bin_total == '0))
        else $error("out-of-store read not zero");

    // Accumulate raises busy once the request is taken
    a_accum_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_accum |=> o_busy)
        else $error("accumulate did not hold busy");

    // Every result strobe traces back to a read request
    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(acc_read, 1) || $past(acc_read, 2))
        else $error("result strobe without read request");

endmodule

bind fixed_width_histogram_unit fwh_checker #(
    .NUM_BINS (NUM_BINS)
) u_fwh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_mode      (i_mode),
    .i_bin_index (i_bin_index),
    .o_valid     (o_valid),
    .o_bin_total (o_bin_total)
);

@@ bench/fixed_width_histogram_unit_test.sv @@
`timescale 1ns / 1ps

module fixed_width_histogram_unit_test;
    import fwh_pkg::*;

    localparam int          NUM_BINS        = 256;
    localparam int          NUM_PHASES      = 10;
    localparam int          ITEMS_PER_PHASE = 153;
    localparam int          SETTLE_CYCLES   = 24;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          NUM_STEPS       = 34;
    localparam logic [1:0]  MODE_UNUSED     = 2'd3;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    // One directed step: a request (code = mode) or a register write (code = index)
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  code;
        logic [15:0] value;
        logic [7:0]  index;
        logic        typed;
        logic [31:0] total;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [MODE_W-1:0]    i_mode;
    logic [SAMPLE_W-1:0]  i_sample;
    logic [IDX_W-1:0]     i_bin_index;
    logic                 o_valid;
    logic [DATA_W-1:0]    o_bin_total;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    // Histogram state as predicted
    logic [31:0]          hist_bins [NUM_BINS];
    logic [15:0]          cfg_min;
    logic [15:0]          cfg_width;
    logic [8:0]           cfg_count;

    logic [31:0]          pending_totals [$];
    logic [31:0]          want_total;
    int unsigned          mismatch_count = 0;
    int unsigned          totals_checked = 0;
    int unsigned          cycle_count = 0;
    int unsigned          n_acc, n_read, n_clear, n_unused, n_cfg;

    // Directed steps: reset contents, field extremes, then the range corner cases
    t_step script [0:NUM_STEPS-1] = '{
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd0,   1'b1, 32'd0},
        '{ROW_REQ, MODE_READ,     16'hFFFF, 8'd255, 1'b1, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'h0000, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'h00FF, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'h7FFF, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'h8000, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'hFFFF, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd0,   1'b1, 32'd1},
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd255, 1'b1, 32'd4},
        '{ROW_REQ, MODE_CLEAR,    16'h0000, 8'd255, 1'b0, 32'd0},
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd255, 1'b1, 32'd0},
        '{ROW_REQ, MODE_UNUSED,   16'h5A5A, 8'hA5,  1'b0, 32'd0},
        '{ROW_REQ, MODE_READ,     16'hA5A5, 8'h5A,  1'b1, 32'd0},
        // Lowest origin, widest bin, zero bin count (one bin in use)
        '{ROW_CFG, CFG_MIN_VALUE, 16'h8000, 8'd0,   1'b0, 32'd0},
        '{ROW_CFG, CFG_BIN_WIDTH, 16'hFFFF, 8'd0,   1'b0, 32'd0},
        '{ROW_CFG, CFG_BIN_COUNT, 16'd0,    8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'h7FFF, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'h8000, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd0,   1'b0, 32'd0},
        // Highest origin, bin count above the store, small negative difference
        '{ROW_CFG, CFG_MIN_VALUE, 16'h7FFF, 8'd0,   1'b0, 32'd0},
        '{ROW_CFG, CFG_BIN_WIDTH, 16'd10,   8'd0,   1'b0, 32'd0},
        '{ROW_CFG, CFG_BIN_COUNT, 16'd300,  8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'h7FF8, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'h8000, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd255, 1'b0, 32'd0},
        // Zero bin width, four bins; touch a bin past the ones in use
        '{ROW_CFG, CFG_BIN_WIDTH, 16'd0,    8'd0,   1'b0, 32'd0},
        '{ROW_CFG, CFG_BIN_COUNT, 16'd4,    8'd0,   1'b0, 32'd0},
        '{ROW_CFG, CFG_MIN_VALUE, 16'h0000, 8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'd3,    8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_ACC,      16'd9,    8'd0,   1'b0, 32'd0},
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd3,   1'b0, 32'd0},
        '{ROW_REQ, MODE_CLEAR,    16'h0000, 8'd200, 1'b0, 32'd0},
        '{ROW_REQ, MODE_READ,     16'h0000, 8'd200, 1'b0, 32'd0}
    };

    fixed_width_histogram_unit #(
        .NUM_BINS(NUM_BINS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_mode     (i_mode),
        .i_sample   (i_sample),
        .i_bin_index(i_bin_index),
        .o_valid    (o_valid),
        .o_bin_total(o_bin_total),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bins in use after clamping the configured count
    function automatic int unsigned bins_used();
        if (cfg_count == 0) return 1;
        if (cfg_count > NUM_BINS) return NUM_BINS;
        return cfg_count;
    endfunction

    // Bin hit by a sample; out-of-range quotients land in the last bin in use
    function automatic int unsigned bin_for_sample(logic [15:0] sample);
        int          diff;
        int unsigned w;
        int unsigned n;
        int unsigned q;
        diff = int'($signed(sample)) - int'($signed(cfg_min));
        w = (cfg_width == 0) ? 1 : cfg_width;
        n = bins_used();
        if (diff < 0) return ((-diff) / w != 0) ? n - 1 : 0;
        q = diff / w;
        if (q >= n) return n - 1;
        return q;
    endfunction

    // Apply one request to the histogram; return 1 when it yields a bin total
    function automatic bit histogram_step(input logic [1:0] mode, input logic [15:0] sample,
                                          input logic [7:0] index, output logic [31:0] total);
        int unsigned b;
        total = '0;
        case (mode)
            MODE_ACC: begin
                // Saturating count
                b = bin_for_sample(sample);
                if (hist_bins[b] != 32'hFFFF_FFFF) hist_bins[b] = hist_bins[b] + 32'd1;
                return 1'b0;
            end
            MODE_READ: begin
                if (int'(index) < NUM_BINS) total = hist_bins[index];
                return 1'b1;
            end
            MODE_CLEAR: begin
                if (int'(index) < NUM_BINS) hist_bins[index] = '0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Drive one request, hold it until accepted, then predict its outcome
    task automatic send_request(input logic [1:0] mode, input logic [15:0] sample,
                                input logic [7:0] index, input int unsigned gap,
                                input bit typed, input logic [31:0] typed_total);
        logic [31:0] total;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_mode      <= mode;
        i_sample    <= sample;
        i_bin_index <= index;
        do @(posedge i_clk); while (o_busy);
        if (histogram_step(mode, sample, index, total))
            pending_totals = {pending_totals, (typed ? typed_total : total)};
        case (mode)
            MODE_ACC:   n_acc++;
            MODE_READ:  n_read++;
            MODE_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
    endtask

    // Drop start and hold until every pending bin total has come back
    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_totals.size() != 0);
    endtask

    // Drain, let a trailing accumulate finish, then wait for busy to drop
    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] index, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_MIN_VALUE: cfg_min   = value;
            CFG_BIN_WIDTH: cfg_width = value;
            CFG_BIN_COUNT: cfg_count = value[8:0];
            default: ;
        endcase
        n_cfg++;
        @(posedge i_clk);
    endtask

    // Mostly samples spread over the bins in use, some just below the origin, some anywhere
    function automatic logic [15:0] pick_sample();
        int unsigned w;
        int unsigned n;
        w = (cfg_width == 0) ? 1 : cfg_width;
        n = bins_used();
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom_range(0, 16'hFFFF));
            2:       return 16'(int'($signed(cfg_min)) - int'($urandom_range(1, w)));
            default: return 16'(int'($signed(cfg_min)) + int'($urandom_range(0, w * n + w)));
        endcase
    endfunction

    // Check each bin total against the oldest pending one
    always @(posedge i_clk) begin
        if (o_valid === 1'b1) begin
            if (pending_totals.size() == 0) begin
                report_mismatch("bin_total with no read pending", o_bin_total, '0);
            end else begin
                want_total = pending_totals.pop_front();
                if (o_bin_total !== want_total)
                    report_mismatch("bin_total", o_bin_total, want_total);
                totals_checked++;
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d totals pending", cycle_count,
                     pending_totals.size());
            $display("fixed_width_histogram_unit_test failed");
            $finish;
        end
    end

    initial begin
        int unsigned phase;
        int unsigned count;
        int unsigned pick;
        bit          no_idle;
        logic [1:0]  mode;
        logic [15:0] width;

        foreach (hist_bins[b]) hist_bins[b] = '0;
        cfg_min        = 16'h0000;
        cfg_width      = 16'd1;
        cfg_count      = 9'd256;
        n_acc = 0; n_read = 0; n_clear = 0; n_unused = 0; n_cfg = 0;
        no_idle = 1'b0;

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_mode      <= MODE_ACC;
        i_sample    <= '0;
        i_bin_index <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_MIN_VALUE;
        i_cfg_wdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the clearing pass after reset finish
        wait_idle();

        // Walk the directed steps
        for (int r = 0; r < NUM_STEPS; r++) begin
            if (script[r].kind == ROW_CFG) begin
                wait_idle();
                write_cfg(script[r].code, script[r].value);
            end else begin
                send_request(script[r].code, script[r].value, script[r].index,
                             $urandom_range(0, 18), script[r].typed, script[r].total);
            end
        end

        // Random phases, each under its own bin layout
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_cfg(CFG_MIN_VALUE, 16'h0000);
                    write_cfg(CFG_BIN_WIDTH, 16'd1);
                    write_cfg(CFG_BIN_COUNT, 16'd256);
                end
                1: begin
                    write_cfg(CFG_MIN_VALUE, 16'h8000);
                    write_cfg(CFG_BIN_WIDTH, 16'd256);
                    write_cfg(CFG_BIN_COUNT, 16'd256);
                end
                2: begin
                    write_cfg(CFG_MIN_VALUE, 16'hFC18);
                    write_cfg(CFG_BIN_WIDTH, 16'd7);
                    write_cfg(CFG_BIN_COUNT, 16'd16);
                end
                3: begin
                    write_cfg(CFG_MIN_VALUE, 16'h7FFF);
                    write_cfg(CFG_BIN_WIDTH, 16'hFFFF);
                    write_cfg(CFG_BIN_COUNT, 16'd1);
                end
                4: begin
                    write_cfg(CFG_MIN_VALUE, 16'h8000);
                    write_cfg(CFG_BIN_WIDTH, 16'hFFFF);
                    write_cfg(CFG_BIN_COUNT, 16'd511);
                end
                5: begin
                    write_cfg(CFG_MIN_VALUE, 16'd100);
                    write_cfg(CFG_BIN_WIDTH, 16'd0);
                    write_cfg(CFG_BIN_COUNT, 16'd257);
                end
                6: begin
                    write_cfg(CFG_MIN_VALUE, 16'hFFF0);
                    write_cfg(CFG_BIN_WIDTH, 16'd3);
                    write_cfg(CFG_BIN_COUNT, 16'd2);
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       width = 16'($urandom_range(1, 40));
                        1:       width = 16'($urandom_range(1, 2000));
                        default: width = 16'($urandom_range(0, 16'hFFFF));
                    endcase
                    write_cfg(CFG_MIN_VALUE, 16'($urandom_range(0, 16'hFFFF)));
                    write_cfg(CFG_BIN_WIDTH, width);
                    write_cfg(CFG_BIN_COUNT, 16'($urandom_range(0, 511)));
                end
            endcase

            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                // Toggle between back-to-back bursts and idle gaps
                if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
                // Pause until all reads have answered, once per phase and now and then
                if (count == ITEMS_PER_PHASE / 2 || $urandom_range(0, 59) == 0)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 55)      mode = MODE_ACC;
                else if (pick < 83) mode = MODE_READ;
                else if (pick < 93) mode = MODE_CLEAR;
                else                mode = MODE_UNUSED;
                send_request(mode, pick_sample(),
                             ($urandom_range(0, 9) < 7) ?
                                 8'($urandom_range(0, bins_used() - 1)) :
                                 8'($urandom_range(0, 255)),
                             no_idle ? 0 : $urandom_range(0, 18), 1'b0, '0);
                count++;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d accumulates, %0d reads, %0d clears and %0d unused-mode requests",
                 n_acc, n_read, n_clear, n_unused);
        $display("over %0d register writes; %0d bin totals checked, %0d mismatches",
                 n_cfg, totals_checked, mismatch_count);
        if (mismatch_count == 0 && pending_totals.size() == 0) begin
            $display("fixed_width_histogram_unit_test passed");
        end else begin
            $display("fixed_width_histogram_unit_test failed");
        end
        $finish;
    end

endmodule

@@ fixed_width_histogram_unit.f @@
rtl/fwh_pkg.sv
rtl/fwh_ram.sv
rtl/fwh_div.sv
rtl/fixed_width_histogram_unit.sv
rtl/fwh_checker.sv
bench/fixed_width_histogram_unit_test.sv
